/* rtl/assert_macros.svh */
// assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define UPG_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
`define UPG_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define UPG_ASSERT(label, clk, rst, prop)
`define UPG_ASSERT_IMPL(label, clk, rst, ante, cons)
`endif
`endif

/* rtl/upg_pkg.sv */
`timescale 1ns / 1ps
package upg_pkg;

   localparam int MAX_PAYLOAD = 2048;
   localparam int MAX_GROUP   = 16;
   localparam int ADDR_W      = $clog2(MAX_PAYLOAD);
   localparam int HDR_BYTES   = 24;
   localparam int Q_DEPTH     = 4;
   localparam int Q_PTR_W     = $clog2(Q_DEPTH);

   typedef enum logic [1:0] {
      OP_MEDIA = 2'd0,
      OP_BUILD = 2'd1,
      OP_PULL  = 2'd2,
      OP_NOP   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      KIND_NONE    = 2'd0,
      KIND_ABANDON = 2'd1,
      KIND_READY   = 2'd2,
      KIND_BYTE    = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      CSR_GROUP_SIZE = 2'd0,
      CSR_MEDIA_SSRC = 2'd1,
      CSR_FEC_PT     = 2'd2
   } csr_type;

   typedef enum logic [1:0] {
      CMD_WRITE  = 2'd0,
      CMD_READ   = 2'd1,
      CMD_RESULT = 2'd2
   } cmd_op_type;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [7:0]  data_byte;
      logic        last_byte;
      logic [31:0] fec_timestamp;
   } req_type;

   typedef struct packed {
      logic [1:0]  out_kind;
      logic [7:0]  out_byte;
      logic        end_of_packet;
      logic [11:0] packet_length;
   } rsp_type;

   // one job from the parser to the store side
   typedef struct packed {
      cmd_op_type        op;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        data;
      logic              xor_en;
      logic [1:0]        kind;
      logic              eop;
      logic [11:0]       len;
   } cmd_type;

endpackage

/* rtl/upg_front.sv */
`timescale 1ns / 1ps
module upg_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  upg_pkg::req_type  req_data,
   input  logic              csr_wr_en,
   input  logic [1:0]        csr_index,
   input  logic [31:0]       csr_wdata,
   output logic              cmd_push,
   output upg_pkg::cmd_type  cmd
);
   import upg_pkg::*;

   logic [4:0]  group_size_ff;
   logic [31:0] media_ssrc_ff;
   logic [6:0]  fec_pt_ff;

   logic [11:0] parity_length_ff, parity_length_in;
   logic [15:0] byte_position_ff, byte_position_in;
   logic [15:0] header_length_ff, header_length_in;
   logic [15:0] seq_ff, seq_in;
   logic [31:0] ts_ff, ts_in;
   logic        mk_ff, mk_in;
   logic        packet_valid_ff, packet_valid_in;
   logic [4:0]  members_ff, members_in;
   logic [15:0] base_seq_ff, base_seq_in;
   logic [15:0] mask_ff, mask_in;
   logic [31:0] ts_par_ff, ts_par_in;
   logic [15:0] len_par_ff, len_par_in;
   logic [15:0] prev_seq_ff, prev_seq_in;
   logic        prev_mk_ff, prev_mk_in;
   logic        contig_ff, contig_in;
   logic        ready_ff, ready_in;
   logic [15:0] parity_seq_ff, parity_seq_in;
   logic [11:0] ro_pos_ff, ro_pos_in;
   logic        ro_active_ff, ro_active_in;
   logic [31:0] ro_ts_ff, ro_ts_in;
   logic [6:0]  ext_base_ff, ext_base_in;
   logic        has_ext_ff, has_ext_in;
   logic        too_big_ff, too_big_in;
   logic        overlong_ff, overlong_in;
   logic [7:0]  ext_hi_ff, ext_hi_in;

   logic [15:0] pos;
   logic [7:0]  b;
   logic        pv;
   logic [15:0] idx;
   logic [18:0] hsum;
   logic [16:0] size;
   logic        acc;
   logic [4:0]  g;
   logic [4:0]  m;
   logic [15:0] off;
   logic [12:0] total;
   logic [15:0] fec_seq;
   logic [31:0] fec_ssrc;

   // parity packet header byte at a given position
   function automatic logic [7:0] hdr_byte(input logic [4:0] p);
      logic [7:0] mkb;
      mkb = {prev_mk_ff, 7'd0};
      unique case (p)
         5'd0:    hdr_byte = 8'h80;
         5'd1:    hdr_byte = mkb | {1'b0, fec_pt_ff};
         5'd2:    hdr_byte = fec_seq[15:8];
         5'd3:    hdr_byte = fec_seq[7:0];
         5'd4:    hdr_byte = ro_ts_ff[31:24];
         5'd5:    hdr_byte = ro_ts_ff[23:16];
         5'd6:    hdr_byte = ro_ts_ff[15:8];
         5'd7:    hdr_byte = ro_ts_ff[7:0];
         5'd8:    hdr_byte = fec_ssrc[31:24];
         5'd9:    hdr_byte = fec_ssrc[23:16];
         5'd10:   hdr_byte = fec_ssrc[15:8];
         5'd11:   hdr_byte = fec_ssrc[7:0];
         5'd12:   hdr_byte = 8'h00;
         5'd13:   hdr_byte = mkb | 8'd96;
         5'd14:   hdr_byte = base_seq_ff[15:8];
         5'd15:   hdr_byte = base_seq_ff[7:0];
         5'd16:   hdr_byte = ts_par_ff[31:24];
         5'd17:   hdr_byte = ts_par_ff[23:16];
         5'd18:   hdr_byte = ts_par_ff[15:8];
         5'd19:   hdr_byte = ts_par_ff[7:0];
         5'd20:   hdr_byte = len_par_ff[15:8];
         5'd21:   hdr_byte = len_par_ff[7:0];
         5'd22:   hdr_byte = mask_ff[15:8];
         default: hdr_byte = mask_ff[7:0];
      endcase
   endfunction

   assign fec_seq  = parity_seq_ff - 16'd1;
   assign fec_ssrc = media_ssrc_ff + 32'd1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         group_size_ff <= 5'd4;
         media_ssrc_ff <= '0;
         fec_pt_ff     <= 7'h7f;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_GROUP_SIZE: group_size_ff <= csr_wdata[4:0];
            CSR_MEDIA_SSRC: media_ssrc_ff <= csr_wdata;
            CSR_FEC_PT:     fec_pt_ff     <= csr_wdata[6:0];
            default:        ;
         endcase
      end
   end

   // parse, group accounting and readout sequencing
   always_comb begin
      parity_length_in = parity_length_ff;
      byte_position_in = byte_position_ff;
      header_length_in = header_length_ff;
      seq_in           = seq_ff;
      ts_in            = ts_ff;
      mk_in            = mk_ff;
      packet_valid_in  = packet_valid_ff;
      members_in       = members_ff;
      base_seq_in      = base_seq_ff;
      mask_in          = mask_ff;
      ts_par_in        = ts_par_ff;
      len_par_in       = len_par_ff;
      prev_seq_in      = prev_seq_ff;
      prev_mk_in       = prev_mk_ff;
      contig_in        = contig_ff;
      ready_in         = ready_ff;
      parity_seq_in    = parity_seq_ff;
      ro_pos_in        = ro_pos_ff;
      ro_active_in     = ro_active_ff;
      ro_ts_in         = ro_ts_ff;
      ext_base_in      = ext_base_ff;
      has_ext_in       = has_ext_ff;
      too_big_in       = too_big_ff;
      overlong_in      = overlong_ff;
      ext_hi_in        = ext_hi_ff;
      cmd_push         = 1'b0;
      cmd              = '0;
      cmd.op           = CMD_RESULT;
      pos   = byte_position_ff;
      b     = req_data.data_byte;
      pv    = 1'b0;
      idx   = pos - header_length_ff;
      hsum  = '0;
      size  = '0;
      acc   = 1'b0;
      g     = (group_size_ff > 5'(MAX_GROUP)) ? 5'(MAX_GROUP) : group_size_ff;
      m     = members_ff + 5'd1;
      off   = '0;
      total = 13'(HDR_BYTES) + {1'b0, parity_length_ff};
      if (accept) begin
         unique case (op_type'(req_data.opcode))
            OP_MEDIA: begin
               if (byte_position_ff == 16'hffff) begin
                  overlong_in = 1'b1;
               end else begin
                  if (pos == 16'd0) begin
                     pv = packet_valid_ff && (b[7:6] == 2'b10) && !ready_ff && !ro_active_ff;
                     packet_valid_in  = pv;
                     ext_base_in      = 7'd12 + {1'b0, b[3:0], 2'b00};
                     has_ext_in       = b[4];
                     header_length_in = 16'(ext_base_in) + (b[4] ? 16'd4 : 16'd0);
                     if (pv && members_ff == 5'd0) parity_length_in = '0;
                  end else begin
                     // fixed header fields
                     unique case (pos)
                        16'd1:   mk_in = b[7];
                        16'd2:   seq_in[15:8] = b;
                        16'd3:   seq_in[7:0] = b;
                        16'd4:   ts_in[31:24] = b;
                        16'd5:   ts_in[23:16] = b;
                        16'd6:   ts_in[15:8] = b;
                        16'd7:   ts_in[7:0] = b;
                        default: ;
                     endcase
                     // extension length, else payload
                     priority if (has_ext_ff && pos == 16'(ext_base_ff) + 16'd2) begin
                        ext_hi_in = b;
                     end else if (has_ext_ff && pos == 16'(ext_base_ff) + 16'd3) begin
                        hsum = 19'(ext_base_ff) + 19'd4 + {1'b0, ext_hi_ff, b, 2'b00};
                        header_length_in = (hsum > 19'hffff) ? 16'hffff : hsum[15:0];
                     end else if (packet_valid_ff && pos >= header_length_ff) begin
                        if (idx < 16'(MAX_PAYLOAD)) begin
                           cmd_push    = 1'b1;
                           cmd.op      = CMD_WRITE;
                           cmd.addr    = idx[ADDR_W-1:0];
                           cmd.data    = b;
                           cmd.xor_en  = idx < 16'(parity_length_ff);
                           if (idx + 16'd1 > 16'(parity_length_ff))
                              parity_length_in = 12'(idx + 16'd1);
                        end else begin
                           too_big_in = 1'b1;
                        end
                     end
                  end
                  byte_position_in = pos + 16'd1;
               end
               // end of media packet
               if (req_data.last_byte) begin
                  size = overlong_in ? 17'h10000 : {1'b0, byte_position_in};
                  acc  = packet_valid_in && (overlong_in || {1'b0, header_length_in} <= size);
                  if (acc) begin
                     if (members_ff == 5'd0) begin
                        base_seq_in = seq_in;
                        mask_in     = '0;
                        ts_par_in   = '0;
                        len_par_in  = '0;
                        contig_in   = 1'b1;
                     end else if (seq_in != prev_seq_ff + 16'd1) begin
                        contig_in = 1'b0;
                     end
                     off = seq_in - base_seq_in;
                     if (off < 16'd16) mask_in = mask_in | (16'h8000 >> off[3:0]);
                     else contig_in = 1'b0;
                     ts_par_in  = ts_par_in ^ ts_in;
                     len_par_in = len_par_in ^ 16'(size - {1'b0, header_length_in});
                     if (too_big_in || overlong_in) contig_in = 1'b0;
                     prev_seq_in = seq_in;
                     prev_mk_in  = mk_in;
                     if (m >= g) begin
                        ready_in   = 1'b1;
                        members_in = '0;
                     end else begin
                        members_in = m;
                     end
                  end
                  byte_position_in = '0;
                  header_length_in = 16'd12;
                  seq_in           = '0;
                  ts_in            = '0;
                  mk_in            = 1'b0;
                  packet_valid_in  = 1'b1;
                  ext_base_in      = 7'd12;
                  has_ext_in       = 1'b0;
                  too_big_in       = 1'b0;
                  overlong_in      = 1'b0;
                  ext_hi_in        = '0;
               end
            end
            OP_BUILD: begin
               cmd_push  = 1'b1;
               cmd.kind  = KIND_NONE;
               if (ready_ff) begin
                  ready_in = 1'b0;
                  if (!contig_ff) begin
                     parity_length_in = '0;
                     cmd.kind = KIND_ABANDON;
                  end else begin
                     parity_seq_in = parity_seq_ff + 16'd1;
                     ro_ts_in      = req_data.fec_timestamp;
                     ro_pos_in     = '0;
                     ro_active_in  = 1'b1;
                     cmd.kind      = KIND_READY;
                     cmd.len       = total[11:0];
                  end
               end
            end
            OP_PULL: begin
               cmd_push = 1'b1;
               cmd.kind = KIND_NONE;
               if (ro_active_ff) begin
                  cmd.kind = KIND_BYTE;
                  if (ro_pos_ff < 12'(HDR_BYTES)) begin
                     cmd.data = hdr_byte(ro_pos_ff[4:0]);
                  end else begin
                     cmd.op   = CMD_READ;
                     cmd.addr = ADDR_W'(ro_pos_ff - 12'(HDR_BYTES));
                  end
                  if ({1'b0, ro_pos_ff} + 13'd1 >= total) begin
                     cmd.eop          = 1'b1;
                     ro_active_in     = 1'b0;
                     ro_pos_in        = '0;
                     parity_length_in = '0;
                  end else begin
                     ro_pos_in = ro_pos_ff + 12'd1;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         parity_length_ff <= '0;
         byte_position_ff <= '0;
         header_length_ff <= 16'd12;
         seq_ff           <= '0;
         ts_ff            <= '0;
         mk_ff            <= 1'b0;
         packet_valid_ff  <= 1'b1;
         members_ff       <= '0;
         base_seq_ff      <= '0;
         mask_ff          <= '0;
         ts_par_ff        <= '0;
         len_par_ff       <= '0;
         prev_seq_ff      <= '0;
         prev_mk_ff       <= 1'b0;
         contig_ff        <= 1'b1;
         ready_ff         <= 1'b0;
         parity_seq_ff    <= '0;
         ro_pos_ff        <= '0;
         ro_active_ff     <= 1'b0;
         ro_ts_ff         <= '0;
         ext_base_ff      <= 7'd12;
         has_ext_ff       <= 1'b0;
         too_big_ff       <= 1'b0;
         overlong_ff      <= 1'b0;
         ext_hi_ff        <= '0;
      end else begin
         parity_length_ff <= parity_length_in;
         byte_position_ff <= byte_position_in;
         header_length_ff <= header_length_in;
         seq_ff           <= seq_in;
         ts_ff            <= ts_in;
         mk_ff            <= mk_in;
         packet_valid_ff  <= packet_valid_in;
         members_ff       <= members_in;
         base_seq_ff      <= base_seq_in;
         mask_ff          <= mask_in;
         ts_par_ff        <= ts_par_in;
         len_par_ff       <= len_par_in;
         prev_seq_ff      <= prev_seq_in;
         prev_mk_ff       <= prev_mk_in;
         contig_ff        <= contig_in;
         ready_ff         <= ready_in;
         parity_seq_ff    <= parity_seq_in;
         ro_pos_ff        <= ro_pos_in;
         ro_active_ff     <= ro_active_in;
         ro_ts_ff         <= ro_ts_in;
         ext_base_ff      <= ext_base_in;
         has_ext_ff       <= has_ext_in;
         too_big_ff       <= too_big_in;
         overlong_ff      <= overlong_in;
         ext_hi_ff        <= ext_hi_in;
      end
   end

endmodule

/* rtl/upg_cmd_queue.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
module upg_cmd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  upg_pkg::cmd_type push_data,
   input  logic             pop,
   output logic             full,
   output logic             empty,
   output upg_pkg::cmd_type head
);
   import upg_pkg::*;

   cmd_type              slot_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [Q_PTR_W:0]     count_ff;
   logic                 do_push, do_pop;

   assign full    = (count_ff == (Q_PTR_W+1)'(Q_DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push_data;
   end

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (do_pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_ff + (Q_PTR_W+1)'(do_push) - (Q_PTR_W+1)'(do_pop);
      end
   end

   `UPG_ASSERT(a_q_level, clock, reset, count_ff <= (Q_PTR_W+1)'(Q_DEPTH))
   `UPG_ASSERT(a_q_ptrs, clock, reset, (count_ff == '0 || count_ff == (Q_PTR_W+1)'(Q_DEPTH)) == (wr_ptr_ff == rd_ptr_ff))

endmodule

/* rtl/upg_back.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
module upg_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   input  upg_pkg::cmd_type cmd,
   output logic             cmd_pop,
   input  logic             rsp_pop,
   output logic             rsp_empty,
   output upg_pkg::rsp_type rsp_data
);
   import upg_pkg::*;

   logic [7:0]         store [MAX_PAYLOAD];
   logic [7:0]         rd_data_ff;
   logic               b_valid_ff;
   cmd_type            b_cmd_ff;
   logic               byp_hit_ff, byp_hit_in;
   logic [7:0]         byp_data_ff;
   logic [7:0]         old_byte, wr_byte;
   logic               b_write, b_result;

   rsp_type            ob_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] ob_wr_ff, ob_rd_ff;
   logic [Q_PTR_W:0]   ob_count_ff;
   logic               ob_pop;
   rsp_type            ob_entry;

   // issue only with room for every result in flight
   assign cmd_pop = cmd_valid &&
      ((ob_count_ff + (Q_PTR_W+1)'(b_valid_ff)) < (Q_PTR_W+1)'(Q_DEPTH));

   // read-modify-write of the parity store, with forwarding of the beat in flight
   assign old_byte = byp_hit_ff ? byp_data_ff : rd_data_ff;
   assign wr_byte  = b_cmd_ff.xor_en ? (old_byte ^ b_cmd_ff.data) : b_cmd_ff.data;
   assign b_write  = b_valid_ff && (b_cmd_ff.op == CMD_WRITE);
   assign b_result = b_valid_ff && (b_cmd_ff.op != CMD_WRITE);
   assign byp_hit_in = b_write && (b_cmd_ff.addr == cmd.addr);

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         rd_data_ff  <= store[cmd.addr];
         byp_data_ff <= wr_byte;
      end
      if (b_write) store[b_cmd_ff.addr] <= wr_byte;
   end

   // second stage
   always_ff @(posedge clock) begin
      if (cmd_pop) b_cmd_ff <= cmd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         byp_hit_ff <= 1'b0;
      end else begin
         b_valid_ff <= cmd_pop;
         byp_hit_ff <= cmd_pop && byp_hit_in;
      end
   end

   // result queue
   always_comb begin
      ob_entry               = '0;
      ob_entry.out_kind      = b_cmd_ff.kind;
      ob_entry.end_of_packet = b_cmd_ff.eop;
      ob_entry.packet_length = b_cmd_ff.len;
      ob_entry.out_byte      = (b_cmd_ff.op == CMD_READ) ? old_byte : b_cmd_ff.data;
   end

   assign rsp_empty = (ob_count_ff == '0);
   assign rsp_data  = ob_ff[ob_rd_ff];
   assign ob_pop    = rsp_pop && !rsp_empty;

   always_ff @(posedge clock) begin
      if (b_result) ob_ff[ob_wr_ff] <= ob_entry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ob_wr_ff    <= '0;
         ob_rd_ff    <= '0;
         ob_count_ff <= '0;
      end else begin
         if (b_result) ob_wr_ff <= ob_wr_ff + 1'b1;
         if (ob_pop)   ob_rd_ff <= ob_rd_ff + 1'b1;
         ob_count_ff <= ob_count_ff + (Q_PTR_W+1)'(b_result) - (Q_PTR_W+1)'(ob_pop);
      end
   end

   `UPG_ASSERT(a_ob_level, clock, reset, ob_count_ff <= (Q_PTR_W+1)'(Q_DEPTH))
   `UPG_ASSERT_IMPL(a_issue_stage, clock, reset, cmd_pop, b_valid_ff)
   `UPG_ASSERT_IMPL(a_ob_hold, clock, reset, !b_valid_ff && !cmd_pop && !ob_pop, $stable(ob_count_ff))

endmodule

/* rtl/ulpfec_parity_generator.sv */
`timescale 1ns / 1ps
// channel   ports                            beat taken when
// request   req_push req_full req_data       req_push && !req_full
// result    rsp_empty rsp_pop rsp_data       rsp_pop && !rsp_empty
// control   csr_wr_en csr_index csr_wdata    csr_wr_en
//
// one request beat per cycle while req_full is low; a result reaches the rsp ports
// through the command queue, the parity store read stage and the result queue.
// the parity store read-modify-write runs in two stages with forwarding.
// reset: synchronous, active high; the parity store is not cleared.
// a full result queue stalls the store side, then the command queue fills
// and raises req_full.
module ulpfec_parity_generator (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  upg_pkg::req_type req_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output upg_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic [1:0]       csr_index,
   input  logic [31:0]      csr_wdata
);
   import upg_pkg::*;

   logic    accept;
   logic    cmd_push, q_empty, q_pop;
   cmd_type cmd_in, cmd_head;

   assign accept = req_push && !req_full;

   upg_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req_data  (req_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd_push  (cmd_push),
      .cmd       (cmd_in)
   );

   upg_cmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in),
      .pop       (q_pop),
      .full      (req_full),
      .empty     (q_empty),
      .head      (cmd_head)
   );

   upg_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (!q_empty),
      .cmd       (cmd_head),
      .cmd_pop   (q_pop),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data)
   );

endmodule
